// File: hw/rtl/plt_pkg.sv
// ----------------------------------------------------------------------------
// plt_pkg
// Shared types, constants and codes of the piecewise linear time table.
// ----------------------------------------------------------------------------
package plt_pkg;

  localparam int unsigned Depth = 64;

  // Operation codes
  localparam logic [1:0] FuncClear  = 2'd0;
  localparam logic [1:0] FuncAppend = 2'd1;
  localparam logic [1:0] FuncQuery  = 2'd2;
  localparam logic [1:0] FuncUnused = 2'd3;

  // Status codes
  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StBefore   = 3'd1;
  localparam logic [2:0] StNotFound = 3'd2;
  localparam logic [2:0] StEmpty    = 3'd3;
  localparam logic [2:0] StFull     = 3'd4;

  // Register indexes
  localparam logic RegInterpMode = 1'b0;

  // Answer select codes
  localparam logic [1:0] SelZero   = 2'd0;
  localparam logic [1:0] SelV0     = 2'd1;
  localparam logic [1:0] SelLast   = 2'd2;
  localparam logic [1:0] SelInterp = 2'd3;

  // Input item payload
  typedef struct packed {
    logic [1:0]         func;
    logic [31:0]        time_point;
    logic signed [31:0] entry_value;
  } plt_in_t;

  // Result item payload
  typedef struct packed {
    logic signed [31:0] result_value;
    logic [2:0]         status;
  } plt_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_item;    // capture input item
    logic load_first;   // capture entry 0 read data
    logic load_last;    // capture last entry read data
    logic load_lo;      // capture lower scan entry
    logic load_hi;      // capture upper scan entry
    logic div_start;    // prepare the division operands
    logic div_step;     // one restoring step
    logic fin_result;   // load the product, clear the divider
  } plt_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic t_lt_first;
    logic t_ge_last;
    logic in_iv;        // t0 <= t < t1
    logic exact;        // t == t0, or interpolation off
  } plt_stat_t;

endpackage

// File: hw/rtl/plt_if.sv
// ----------------------------------------------------------------------------
// plt_if
// Valid/ready channel carrying one item payload of type PT.
// ----------------------------------------------------------------------------
interface plt_if #(
  parameter type PT = logic
);
  logic valid;
  logic ready;
  PT    data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/piecewise_linear_time_table.sv
// ----------------------------------------------------------------------------
// piecewise_linear_time_table
// Breakpoint table with step or linear interpolated lookup.
// ----------------------------------------------------------------------------
// Clear and append go from acceptance straight to the result hand-off. A
// query reads the first and last entries, then scans the intervals one by
// one through the single port table memories, and an interpolated answer
// adds a setup state, a multiply state and a bit serial restoring divider
// before the result hand-off. One item is in work at a time.
module piecewise_linear_time_table #(
  parameter int unsigned Depth = plt_pkg::Depth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  plt_if.sink         in_if,
  plt_if.source       out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  plt_pkg::plt_cmd_t   cmd;
  plt_pkg::plt_stat_t  stat;
  logic                interp_q;
  logic                we;
  logic [$clog2(Depth)-1:0] addr;
  logic [1:0]          sel;
  logic [2:0]          status;
  logic [31:0]         result;

  // Configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interp_q <= 1'b1;
    end else if (psel && penable && pwrite && paddr == {plt_pkg::RegInterpMode, 2'b00}) begin
      interp_q <= pwdata[0];
    end
  end
  assign prdata = (paddr == {plt_pkg::RegInterpMode, 2'b00}) ? {31'd0, interp_q} : 32'd0;

  plt_ctrl #(.Depth(Depth)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_func_i(in_if.data.func), .in_ready_o(in_if.ready),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .cmd_o(cmd), .stat_i(stat), .we_o(we), .addr_o(addr),
    .sel_o(sel), .status_o(status)
  );

  plt_datapath #(.Depth(Depth)) u_dp (
    .clk_i, .interp_i(interp_q), .cmd_i(cmd), .we_i(we), .addr_i(addr),
    .in_time_i(in_if.data.time_point), .in_value_i(in_if.data.entry_value),
    .sel_i(sel), .stat_o(stat), .result_o(result)
  );

  // Drive the result item
  assign out_if.data.status       = status;
  assign out_if.data.result_value = result;

  // Output stays until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid)
    else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> $stable(out_if.data))
    else $error("result changed while waiting");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> !in_if.ready)
    else $error("input taken during result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> out_if.data.status <= plt_pkg::StFull)
    else $error("bad status code");
endmodule

// File: hw/rtl/plt_ram.sv
// ----------------------------------------------------------------------------
// plt_ram
// Single port RAM with registered read data.
// ----------------------------------------------------------------------------
module plt_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write or read one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// File: hw/rtl/plt_datapath.sv
// ----------------------------------------------------------------------------
// plt_datapath
// Item registers, table memories, compares and a serial divider.
// ----------------------------------------------------------------------------
module plt_datapath #(
  parameter int unsigned Depth = plt_pkg::Depth
) (
  input  logic                     clk_i,
  input  logic                     interp_i,
  input  plt_pkg::plt_cmd_t        cmd_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [31:0]              in_time_i,
  input  logic [31:0]              in_value_i,
  input  logic [1:0]               sel_i,
  output plt_pkg::plt_stat_t       stat_o,
  output logic [31:0]              result_o
);
  logic [31:0] t_q, rt, rv;
  logic [31:0] t0_q, t1_q;
  logic signed [31:0] v0_q, v1_q;
  logic signed [31:0] vl_q;
  logic [31:0] tf_q, tl_q;
  logic        neg_q;
  logic [32:0] mag_q;
  logic [31:0] num_q, den_q;
  logic [64:0] rem_q;       // partial remainder
  logic [64:0] prod_q;      // mag * num, shifted out one bit a step
  logic [31:0] quo_q;
  logic [32:0] dv;
  logic [65:0] trial;
  logic [31:0] res;

  plt_ram #(.Width(32), .Depth(Depth)) u_time (
    .clk_i, .we_i, .addr_i, .wdata_i(in_time_i), .rdata_o(rt)
  );
  plt_ram #(.Width(32), .Depth(Depth)) u_value (
    .clk_i, .we_i, .addr_i, .wdata_i(in_value_i), .rdata_o(rv)
  );

  assign dv = {v1_q[31], v1_q} - {v0_q[31], v0_q};
  assign trial = {rem_q, prod_q[64]} - {34'd0, den_q};

  // Hold operands, divider state
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) t_q <= in_time_i;
    if (cmd_i.load_first) begin
      tf_q <= rt;
    end
    if (cmd_i.load_last) begin
      tl_q <= rt;
      vl_q <= rv;
    end
    if (cmd_i.load_lo) begin
      t0_q <= rt;
      v0_q <= rv;
    end
    if (cmd_i.load_hi) begin
      t1_q <= rt;
      v1_q <= rv;
    end
    if (cmd_i.div_start) begin
      neg_q <= dv[32];
      mag_q <= dv[32] ? (~dv + 33'd1) : dv;
      num_q <= t1_q - t_q;
      den_q <= t1_q - t0_q;
    end
    if (cmd_i.fin_result) begin
      // Product cycle: 33x32 multiply, registered before the division
      prod_q <= 65'(mag_q) * 65'(num_q);
      rem_q  <= '0;
      quo_q  <= '0;
    end
    if (cmd_i.div_step) begin
      prod_q <= {prod_q[63:0], 1'b0};
      if (!trial[65]) begin
        rem_q <= trial[64:0];
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= {rem_q[63:0], prod_q[64]};
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

  // Quotient stays below |dv|, so the answer fits in 32 bits
  assign res = neg_q ? (v1_q + quo_q) : (v1_q - quo_q);

  always_comb begin
    stat_o.t_lt_first = t_q < tf_q;
    stat_o.t_ge_last  = t_q >= tl_q;
    stat_o.in_iv      = (t_q >= t0_q) && (t_q < t1_q);
    stat_o.exact      = (t_q == t0_q) || !interp_i;
  end

  // Select the answer
  always_comb begin
    case (sel_i)
      plt_pkg::SelV0:     result_o = v0_q;
      plt_pkg::SelLast:   result_o = vl_q;
      plt_pkg::SelInterp: result_o = res;
      default:            result_o = '0;
    endcase
  end
endmodule

// File: hw/rtl/plt_ctrl.sv
// ----------------------------------------------------------------------------
// plt_ctrl
// Sequencer: accepts items, walks the table and steps the divider.
// ----------------------------------------------------------------------------
module plt_ctrl #(
  parameter int unsigned Depth = plt_pkg::Depth
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic [1:0]               in_func_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output plt_pkg::plt_cmd_t        cmd_o,
  input  plt_pkg::plt_stat_t       stat_i,
  output logic                     we_o,
  output logic [$clog2(Depth)-1:0] addr_o,
  output logic [1:0]               sel_o,     // answer select code
  output logic [2:0]               status_o
);
  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned CW = $clog2(Depth + 1);

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SRdF   = 4'd1;
  localparam logic [3:0] SRdL   = 4'd2;
  localparam logic [3:0] SChk   = 4'd3;
  localparam logic [3:0] SRdLo  = 4'd4;
  localparam logic [3:0] SRdHi  = 4'd5;
  localparam logic [3:0] STest  = 4'd6;
  localparam logic [3:0] SPrep  = 4'd7;
  localparam logic [3:0] SMul   = 4'd8;
  localparam logic [3:0] SDiv   = 4'd9;
  localparam logic [3:0] SOut   = 4'd10;
  localparam logic [3:0] SRdLoW = 4'd11;
  localparam logic [3:0] SRdHiW = 4'd12;
  localparam logic [3:0] SWaitL = 4'd13;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [6:0]    step_q, step_d;
  logic [1:0]    sel_q, sel_d;
  logic [2:0]    st_q, st_d;
  logic          go;

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = (state_q == SOut);
  assign go          = in_valid_i && in_ready_o;
  assign sel_o       = sel_q;
  assign status_o    = st_q;

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    idx_d   = idx_q;
    step_d  = step_q;
    sel_d   = sel_q;
    st_d    = st_q;
    cmd_o   = '0;
    we_o    = 1'b0;
    addr_o  = idx_q;
    case (state_q)
      SIdle: begin
        addr_o = count_q[AW-1:0];
        if (go) begin
          cmd_o.load_item = 1'b1;
          sel_d = plt_pkg::SelZero;
          st_d  = plt_pkg::StOk;
          state_d = SOut;
          case (in_func_i)
            plt_pkg::FuncClear: count_d = '0;
            plt_pkg::FuncAppend: begin
              if (count_q >= CW'(Depth)) begin
                st_d = plt_pkg::StFull;
              end else begin
                we_o = 1'b1;
                count_d = count_q + CW'(1);
              end
            end
            plt_pkg::FuncQuery: begin
              if (count_q == '0) begin
                st_d = plt_pkg::StEmpty;
              end else begin
                addr_o = '0;
                state_d = SRdF;
              end
            end
            default: ;
          endcase
        end
      end
      SRdF: begin
        cmd_o.load_first = 1'b1;
        addr_o = AW'(count_q - CW'(1));
        state_d = SWaitL;
      end
      SWaitL: begin
        addr_o = AW'(count_q - CW'(1));
        state_d = SRdL;
      end
      SRdL: begin
        cmd_o.load_last = 1'b1;
        state_d = SChk;
      end
      SChk: begin
        idx_d = '0;
        if (stat_i.t_lt_first) begin
          st_d = plt_pkg::StBefore;
          state_d = SOut;
        end else if (stat_i.t_ge_last) begin
          sel_d = plt_pkg::SelLast;
          state_d = SOut;
        end else begin
          addr_o = '0;
          state_d = SRdLoW;
        end
      end
      SRdLoW: begin
        addr_o = idx_q;
        state_d = SRdLo;
      end
      SRdLo: begin
        cmd_o.load_lo = 1'b1;
        addr_o = idx_q + AW'(1);
        state_d = SRdHiW;
      end
      SRdHiW: begin
        addr_o = idx_q + AW'(1);
        state_d = SRdHi;
      end
      SRdHi: begin
        cmd_o.load_hi = 1'b1;
        state_d = STest;
      end
      STest: begin
        if (stat_i.in_iv) begin
          if (stat_i.exact) begin
            sel_d = plt_pkg::SelV0;
            state_d = SOut;
          end else begin
            state_d = SPrep;
          end
        end else if (CW'(idx_q) + CW'(2) >= count_q) begin
          st_d = plt_pkg::StNotFound;
          state_d = SOut;
        end else begin
          idx_d = idx_q + AW'(1);
          state_d = SRdLoW;
        end
      end
      SPrep: begin
        cmd_o.div_start = 1'b1;
        state_d = SMul;
      end
      SMul: begin
        cmd_o.fin_result = 1'b1;
        step_d = '0;
        state_d = SDiv;
      end
      SDiv: begin
        cmd_o.div_step = 1'b1;
        step_d = step_q + 7'd1;
        if (step_q == 7'd64) begin
          sel_d = plt_pkg::SelInterp;
          state_d = SOut;
        end
      end
      SOut: begin
        if (out_ready_i) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      count_q <= '0;
      idx_q   <= '0;
      step_q  <= '0;
      sel_q   <= plt_pkg::SelZero;
      st_q    <= plt_pkg::StOk;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      step_q  <= step_d;
      sel_q   <= sel_d;
      st_q    <= st_d;
    end
  end
endmodule
